/* hdl/tmie_pkg.sv */
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared types and constants of the tape machine instruction executor.
// ----------------------------------------------------------------------------
package tmie_pkg;

  localparam int OP_W      = 5;
  localparam int OFF_W     = 16;
  localparam int DELTA_W   = OFF_W + 1;
  localparam int DELTA_MAX = 32768;

  typedef enum logic [OP_W-1:0] {
    OP_NEXT        = 5'd0,
    OP_PREV        = 5'd1,
    OP_NEXT_N      = 5'd2,
    OP_PREV_N      = 5'd3,
    OP_INC         = 5'd4,
    OP_DEC         = 5'd5,
    OP_ADD         = 5'd6,
    OP_SUB         = 5'd7,
    OP_INC_AT      = 5'd8,
    OP_DEC_AT      = 5'd9,
    OP_ADD_AT      = 5'd10,
    OP_SUB_AT      = 5'd11,
    OP_PUT         = 5'd12,
    OP_GET         = 5'd13,
    OP_LOOP_START  = 5'd14,
    OP_LOOP_END    = 5'd15,
    OP_ZERO        = 5'd16,
    OP_ASSIGN      = 5'd17,
    OP_ASSIGN_AT   = 5'd18,
    OP_SEARCH_ZERO = 5'd19,
    OP_ADD_VAR     = 5'd20,
    OP_SUB_VAR     = 5'd21,
    OP_CMUL_VAR    = 5'd22,
    OP_INF_LOOP    = 5'd23
  } op_e;

  typedef logic signed [DELTA_W-1:0] delta_t;

endpackage

/* hdl/tmie_wrap.sv */
// ----------------------------------------------------------------------------
// tmie_wrap
// Address unit: base plus signed delta, reduced modulo the tape depth by
// one conditional subtract per cycle; power-of-two depths need none.
// ----------------------------------------------------------------------------
module tmie_wrap import tmie_pkg::*; #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] base_i,
  input  delta_t            delta_i,
  output logic              busy_o,
  output logic [ADDR_W-1:0] result_o
);

  localparam int  SW      = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 2;
  localparam int  BIAS    = DEPTH * ((DELTA_MAX + DEPTH - 1) / DEPTH);
  localparam int  KMAX    = SW - ADDR_W;
  localparam int  KW      = $clog2(KMAX + 1);
  localparam bit  IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

  logic [SW-1:0] v_q, v_d;
  logic [KW-1:0] k_q, k_d;
  logic          busy_q, busy_d;
  logic [SW:0]   step_w;
  logic [SW:0]   v_ext;
  logic [SW-1:0] v_init;

  assign v_init = SW'(base_i) + {{(SW-DELTA_W){delta_i[DELTA_W-1]}}, delta_i} + SW'(BIAS);
  assign step_w = (SW+1)'(DEPTH) << k_q;
  assign v_ext  = {1'b0, v_q};

  always_comb begin
    v_d    = v_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (start_i) begin
      v_d    = v_init;
      k_d    = KW'(KMAX);
      busy_d = !IS_POW2;
    end else if (busy_q) begin
      if (v_ext >= step_w) begin
        v_d = SW'(v_ext - step_w);
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q - KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      v_q    <= '0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      v_q    <= v_d;
      k_q    <= k_d;
    end
  end

  assign busy_o   = busy_q;
  assign result_o = v_q[ADDR_W-1:0];

endmodule

/* hdl/tmie_tape_ram.sv */
// ----------------------------------------------------------------------------
// tmie_tape_ram
// Single-port byte tape, synchronous write, registered read.
// ----------------------------------------------------------------------------
module tmie_tape_ram import tmie_pkg::*; #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tape_machine_ir_executor_top.sv */
// ----------------------------------------------------------------------------
// tape_machine_ir_executor_top
// Executes one optimised tape machine instruction per transfer.
// Path: CELL reads the current cell; WRAP waits for the modulo unit, slower
//   for non-power-of-two depths; MODQ updates the target cell of offset ops
//   and of move ops on a nonzero cell, then CLRP clears the current cell; FIN
//   waits for a free result slot. Zero search loops SCELL and WRAP per cell.
// One item at a time; in_stall_o high from transfer until the result is queued.
// Reset: pointer cleared, then a pass over every address zeroes the tape.
// ----------------------------------------------------------------------------
module tape_machine_ir_executor_top import tmie_pkg::*; #(
  parameter int TAPE_DEPTH = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic signed [15:0] offset_i,
  input  logic [7:0]         amount_i,
  input  logic [15:0]        target_i,
  input  logic [7:0]         input_char_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         out_char_o,
  output logic               jump_taken_o,
  output logic [15:0]        jump_target_o,
  output logic               hang_o
);

  localparam int ADDR_W = $clog2(TAPE_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CELL  = 4'd2;
  localparam logic [3:0] ST_WRAP  = 4'd3;
  localparam logic [3:0] ST_SCELL = 4'd4;
  localparam logic [3:0] ST_MODQ  = 4'd5;
  localparam logic [3:0] ST_CLRP  = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        c_q, c_d;
  logic [7:0]        prod_q, prod_d;
  logic              shang_q, shang_d;

  logic [OP_W-1:0]   op_q;
  logic [15:0]       off_q;
  logic [7:0]        amt_q;
  logic [15:0]       tgt_q;
  logic [7:0]        ich_q;

  logic              res_valid_q;
  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              jump_taken_q;
  logic [15:0]       jump_target_q;
  logic              hang_q;

  logic              accept;
  logic              res_free;
  logic              res_load;
  delta_t            in_delta;
  delta_t            off_delta;
  delta_t            wrap_delta;
  logic [ADDR_W-1:0] wrap_base;
  logic              wrap_start;
  logic              wrap_busy;
  logic [ADDR_W-1:0] wrap_res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic [15:0]       prod_full;
  logic [7:0]        pval;
  logic [7:0]        qval;
  logic              jt;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign res_free  = !res_valid_q || !res_stall_i;
  assign off_delta = {off_q[15], off_q};
  assign prod_full = mem_rdata * amt_q;

  always_comb begin
    unique case (operation_i) inside
      OP_NEXT:   in_delta = DELTA_W'(1);
      OP_PREV:   in_delta = '1;
      OP_PREV_N: in_delta = -{offset_i[15], offset_i};
      default:   in_delta = {offset_i[15], offset_i};
    endcase
  end

  always_comb begin
    unique case (op_q) inside
      OP_INC:    pval = c_q + 8'd1;
      OP_DEC:    pval = c_q - 8'd1;
      OP_ADD:    pval = c_q + off_q[7:0];
      OP_SUB:    pval = c_q - off_q[7:0];
      OP_GET:    pval = ich_q;
      OP_ASSIGN: pval = off_q[7:0];
      default:   pval = 8'd0;
    endcase
  end

  always_comb begin
    unique case (op_q) inside
      OP_INC_AT:   qval = mem_rdata + 8'd1;
      OP_DEC_AT:   qval = mem_rdata - 8'd1;
      OP_ADD_AT:   qval = mem_rdata + amt_q;
      OP_SUB_AT:   qval = mem_rdata - amt_q;
      OP_ADD_VAR:  qval = mem_rdata + c_q;
      OP_SUB_VAR:  qval = mem_rdata - c_q;
      OP_CMUL_VAR: qval = mem_rdata + prod_q;
      default:     qval = mem_rdata;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    c_d        = c_q;
    prod_d     = prod_q;
    shang_d    = shang_q;
    wrap_start = 1'b0;
    wrap_base  = ptr_q;
    wrap_delta = in_delta;
    mem_we     = 1'b0;
    mem_addr   = ptr_q;
    mem_wdata  = 8'd0;
    res_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == ADDR_W'(TAPE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          wrap_start = 1'b1;
          cnt_d      = '0;
          shang_d    = 1'b0;
          state_d    = ST_CELL;
        end
      end
      ST_CELL: begin
        c_d     = mem_rdata;
        prod_d  = prod_full[7:0];
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (!wrap_busy) begin
          state_d = ST_FIN;
          unique case (op_q) inside
            OP_NEXT, OP_PREV, OP_NEXT_N, OP_PREV_N: begin
              ptr_d = wrap_res;
            end
            OP_INC, OP_DEC, OP_ADD, OP_SUB, OP_GET, OP_ZERO, OP_ASSIGN: begin
              mem_we    = 1'b1;
              mem_wdata = pval;
            end
            OP_INC_AT, OP_DEC_AT, OP_ADD_AT, OP_SUB_AT: begin
              mem_addr = wrap_res;
              state_d  = ST_MODQ;
            end
            OP_ASSIGN_AT: begin
              mem_we    = 1'b1;
              mem_addr  = wrap_res;
              mem_wdata = amt_q;
            end
            OP_ADD_VAR, OP_SUB_VAR, OP_CMUL_VAR: begin
              if (c_q != 8'd0) begin
                mem_addr = wrap_res;
                state_d  = ST_MODQ;
              end
            end
            OP_SEARCH_ZERO: begin
              if (c_q != 8'd0) begin
                if (cnt_q == CNT_W'(TAPE_DEPTH)) begin
                  shang_d = 1'b1;
                end else begin
                  ptr_d    = wrap_res;
                  mem_addr = wrap_res;
                  cnt_d    = cnt_q + CNT_W'(1);
                  state_d  = ST_SCELL;
                end
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SCELL: begin
        c_d        = mem_rdata;
        wrap_start = 1'b1;
        wrap_delta = off_delta;
        state_d    = ST_WRAP;
      end
      ST_MODQ: begin
        mem_we    = 1'b1;
        mem_addr  = wrap_res;
        mem_wdata = qval;
        if (op_q == OP_ADD_VAR || op_q == OP_SUB_VAR || op_q == OP_CMUL_VAR) begin
          state_d = ST_CLRP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_CLRP: begin
        mem_we  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (res_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      shang_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      shang_q <= shang_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    prod_q <= prod_d;
    if (accept) begin
      op_q  <= operation_i;
      off_q <= offset_i;
      amt_q <= amount_i;
      tgt_q <= target_i;
      ich_q <= input_char_i;
    end
  end

  assign jt = (op_q == OP_LOOP_START && c_q == 8'd0) ||
              (op_q == OP_LOOP_END && c_q != 8'd0);

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_valid_q   <= (op_q == OP_PUT);
      out_char_q    <= (op_q == OP_PUT) ? c_q : 8'd0;
      jump_taken_q  <= jt;
      jump_target_q <= jt ? tgt_q : 16'd0;
      hang_q        <= (op_q == OP_INF_LOOP && c_q != 8'd0) ||
                       (op_q == OP_SEARCH_ZERO && shang_q);
    end
  end

  tmie_wrap #(
    .DEPTH  (TAPE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wrap_start),
    .base_i   (wrap_base),
    .delta_i  (wrap_delta),
    .busy_o   (wrap_busy),
    .result_o (wrap_res)
  );

  tmie_tape_ram #(
    .DEPTH  (TAPE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign jump_taken_o  = jump_taken_q;
  assign jump_target_o = jump_target_q;
  assign hang_o        = hang_q;

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < CNT_W'(TAPE_DEPTH))
    else $error("data pointer outside tape");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TAPE_DEPTH))
    else $error("zero search ran past tape depth");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && res_valid_q && res_stall_i) |=> (state_q == ST_FIN))
    else $error("result overwritten while pending");

  a_mem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("tape written while idle");

endmodule

/* dv/tape_machine_ir_executor_top_test.sv */
// ----------------------------------------------------------------------------
// tape_machine_ir_executor_top_test
// Self-checking bench for the tape machine executor. A short table of
// directed instructions is followed by random ones. Each untyped result is
// checked against a local model of the tape and the data pointer. Both
// sides insert random gaps, and one long result hold-off backs up the input.
// ----------------------------------------------------------------------------
module tape_machine_ir_executor_top_test;
  import tmie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE_DEPTH  = 32768;
  localparam int ADDR_W      = 15;
  localparam int RAND_ITEMS  = 1900;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [OP_W-1:0] OP_RESERVED_BASE = 5'd24;
  localparam logic [OP_W-1:0] OP_RESERVED_TOP  = 5'd31;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [15:0]     offset;
    logic [7:0]      amount;
    logic [15:0]     target;
    logic [7:0]      in_char;
  } instr_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_char;
    logic        jump_taken;
    logic [15:0] jump_target;
    logic        hang;
  } result_t;

  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t want;
  } row_t;

  localparam result_t NO_RES = '0;

  // typed rows carry their own expectation, the rest use the tape model
  localparam row_t DIR_ROWS [29] = '{
    '{'{OP_PUT, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b1, 8'h00, 1'b0, 16'h0000, 1'b0}},
    '{'{OP_LOOP_START, 16'h0000, 8'h00, 16'hFFFF, 8'h00}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b0}},
    '{'{OP_RESERVED_TOP, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, NO_RES},
    '{'{OP_GET, 16'h0000, 8'h00, 16'h0000, 8'hFF}, 1'b0, NO_RES},
    '{'{OP_PUT, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0}},
    '{'{OP_INF_LOOP, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}},
    '{'{OP_LOOP_END, 16'h0000, 8'h00, 16'hABCD, 8'h00}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 16'hABCD, 1'b0}},
    '{'{OP_SEARCH_ZERO, 16'h8000, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}},
    '{'{OP_INC, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_DEC, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ADD, 16'h7FFF, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_SUB, 16'h8000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_NEXT_N, 16'h7FFF, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_NEXT, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_PREV, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_PREV_N, 16'h8000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_INC_AT, 16'hFFFF, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_DEC_AT, 16'h0001, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ADD_AT, 16'h7FFF, 8'hFF, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_SUB_AT, 16'h8000, 8'h80, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ZERO, 16'h0000, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ASSIGN, 16'h00AA, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ASSIGN_AT, 16'hFFFE, 8'h55, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_SUB_VAR, 16'hFFFE, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_NEXT_N, 16'hFFFE, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ADD_VAR, 16'h0002, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_ADD, 16'h0003, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_CMUL_VAR, 16'h0000, 8'h07, 16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_SEARCH_ZERO, 16'h0001, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RES}
  };

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            in_valid     = 1'b0;
  logic            in_stall;
  logic [OP_W-1:0] op_in        = '0;
  logic [15:0]     offset_in    = '0;
  logic [7:0]      amount_in    = '0;
  logic [15:0]     target_in    = '0;
  logic [7:0]      in_char_in   = '0;
  logic            res_valid;
  logic            res_stall    = 1'b0;
  logic            out_valid;
  logic [7:0]      out_char;
  logic            jump_taken;
  logic [15:0]     jump_target;
  logic            hang;

  logic [7:0] tape_img [TAPE_DEPTH];
  addr_t      ptr_img = '0;
  result_t    expected_q [$];
  int         err_cnt   = 0;
  int         hold_cnt  = 0;
  int         cycle_cnt = 0;
  bit         calm      = 1'b0;

  tape_machine_ir_executor_top #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (op_in),
    .offset_i     (offset_in),
    .amount_i     (amount_in),
    .target_i     (target_in),
    .input_char_i (in_char_in),
    .res_valid_o  (res_valid),
    .res_stall_i  (res_stall),
    .out_valid_o  (out_valid),
    .out_char_o   (out_char),
    .jump_taken_o (jump_taken),
    .jump_target_o(jump_target),
    .hang_o       (hang)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t execute_instr(instr_t ins);
    result_t    res;
    addr_t      at;
    logic [7:0] cur_val;
    res     = '0;
    at      = ptr_img + ins.offset[ADDR_W-1:0];
    cur_val = tape_img[ptr_img];
    case (ins.op)
      OP_NEXT:       ptr_img = ptr_img + 1'b1;
      OP_PREV:       ptr_img = ptr_img - 1'b1;
      OP_NEXT_N:     ptr_img = at;
      OP_PREV_N:     ptr_img = ptr_img - ins.offset[ADDR_W-1:0];
      OP_INC:        tape_img[ptr_img] = cur_val + 8'd1;
      OP_DEC:        tape_img[ptr_img] = cur_val - 8'd1;
      OP_ADD:        tape_img[ptr_img] = cur_val + ins.offset[7:0];
      OP_SUB:        tape_img[ptr_img] = cur_val - ins.offset[7:0];
      OP_INC_AT:     tape_img[at] = tape_img[at] + 8'd1;
      OP_DEC_AT:     tape_img[at] = tape_img[at] - 8'd1;
      OP_ADD_AT:     tape_img[at] = tape_img[at] + ins.amount;
      OP_SUB_AT:     tape_img[at] = tape_img[at] - ins.amount;
      OP_PUT: begin
        res.out_valid = 1'b1;
        res.out_char  = cur_val;
      end
      OP_GET:        tape_img[ptr_img] = ins.in_char;
      OP_LOOP_START: begin
        if (cur_val == 8'd0) begin
          res.jump_taken  = 1'b1;
          res.jump_target = ins.target;
        end
      end
      OP_LOOP_END: begin
        if (cur_val != 8'd0) begin
          res.jump_taken  = 1'b1;
          res.jump_target = ins.target;
        end
      end
      OP_ZERO:       tape_img[ptr_img] = 8'd0;
      OP_ASSIGN:     tape_img[ptr_img] = ins.offset[7:0];
      OP_ASSIGN_AT:  tape_img[at] = ins.amount;
      OP_SEARCH_ZERO: begin
        for (int i = 0; i < TAPE_DEPTH && tape_img[ptr_img] != 8'd0; i++)
          ptr_img = ptr_img + ins.offset[ADDR_W-1:0];
        res.hang = (tape_img[ptr_img] != 8'd0);
      end
      // aliased offsets: the update lands first, then the cell is cleared
      OP_ADD_VAR: begin
        if (cur_val != 8'd0) begin
          tape_img[at]      = tape_img[at] + cur_val;
          tape_img[ptr_img] = 8'd0;
        end
      end
      OP_SUB_VAR: begin
        if (cur_val != 8'd0) begin
          tape_img[at]      = tape_img[at] - cur_val;
          tape_img[ptr_img] = 8'd0;
        end
      end
      OP_CMUL_VAR: begin
        if (cur_val != 8'd0) begin
          tape_img[at]      = tape_img[at] + 8'(cur_val * ins.amount);
          tape_img[ptr_img] = 8'd0;
        end
      end
      OP_INF_LOOP:   res.hang = (cur_val != 8'd0);
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) ins.op = OP_RESERVED_BASE + 5'($urandom_range(0, 7));
    else ins.op = 5'($urandom_range(0, 23));
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      ins.offset = 16'(int'($urandom_range(0, 16)) - 8);
    end else if (sel < 9) begin
      ins.offset = 16'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0:       ins.offset = 16'h7FFF;
        1:       ins.offset = 16'h8000;
        2:       ins.offset = 16'hFFFF;
        default: ins.offset = 16'h0000;
      endcase
    end
    // a step that is a whole tape length would walk the full tape
    if (ins.op == OP_SEARCH_ZERO && ins.offset[ADDR_W-1:0] == '0) ins.offset[0] = 1'b1;
    ins.amount  = 8'($urandom());
    ins.target  = 16'($urandom());
    ins.in_char = 8'($urandom());
    return ins;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic issue(input instr_t ins, input logic typed, input result_t want);
    int      gap;
    result_t pred;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    op_in      <= ins.op;
    offset_in  <= ins.offset;
    amount_in  <= ins.amount;
    target_in  <= ins.target;
    in_char_in <= ins.in_char;
    do @(posedge clk); while (in_stall);
    pred = execute_instr(ins);
    expected_q.push_back(typed ? want : pred);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_cnt;
    int free_cnt;
    stall_cnt = 0;
    free_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        if (free_cnt > 0) begin
          free_cnt--;
        end else begin
          stall_cnt = calm ? 0 : pick_gap();
          free_cnt  = $urandom_range(0, 20);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_valid", 16'(want.out_valid), 16'(out_valid));
        check_field("out_char", 16'(want.out_char), 16'(out_char));
        check_field("jump_taken", 16'(want.jump_taken), 16'(jump_taken));
        check_field("jump_target", want.jump_target, jump_target);
        check_field("hang", 16'(want.hang), 16'(hang));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    foreach (tape_img[i]) tape_img[i] = 8'd0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) issue(DIR_ROWS[i].ins, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == HOLD_AT) hold_cnt = HOLD_CYCLES;
      issue(rand_instr(), 1'b0, NO_RES);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
